// ----- hw/rtl/shva_pkg.sv -----
// Package with widths, constants and helper functions of the vector angle unit.
package shva_pkg;

    // Field widths of the stream items.
    localparam int COMPONENT_WIDTH = 16;
    localparam int HEADING_WIDTH   = 17;
    localparam int ANGLE_WIDTH     = 16;

    // Number of cells per CORDIC chain, limited by the arctangent table.
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int N_STG         = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int SH_W          = 5;

    // Datapath widths: four guard bits plus headroom for CORDIC gain and sqrt(3).
    localparam int GUARD_BITS = 4;
    localparam int D_W        = COMPONENT_WIDTH + GUARD_BITS + 5;
    localparam int A_W        = HEADING_WIDTH + 9;
    localparam int K_W        = 25;
    localparam int P_W        = D_W + K_W;

    // Angles are in 2^-15 degree inside the chains, 1/128 degree at the ports.
    localparam int HALF_TURN = 23040;
    localparam int FULL_TURN = 46080;
    localparam logic signed [A_W-1:0] DEG90 = A_W'(11520 * 256);
    localparam logic signed [K_W-1:0] KINV_Q24 = K_W'(10188012);

    // Sideband carried along the chains.
    typedef struct packed {
        logic                  zero;
        logic                  yneg;
        logic signed [D_W-1:0] xp;
        logic signed [D_W-1:0] z;
    } t_side;

    // Arctangent of 2^-i in 2^-15 degree.
    function automatic logic signed [A_W-1:0] atan_q(input int idx);
        logic signed [A_W-1:0] v;
        unique case (idx)
            0:  v = A_W'(1474560);
            1:  v = A_W'(870484);
            2:  v = A_W'(459940);
            3:  v = A_W'(233473);
            4:  v = A_W'(117189);
            5:  v = A_W'(58652);
            6:  v = A_W'(29333);
            7:  v = A_W'(14667);
            8:  v = A_W'(7334);
            9:  v = A_W'(3667);
            10: v = A_W'(1833);
            11: v = A_W'(917);
            12: v = A_W'(458);
            13: v = A_W'(229);
            14: v = A_W'(115);
            15: v = A_W'(57);
            16: v = A_W'(29);
            17: v = A_W'(14);
            18: v = A_W'(7);
            19: v = A_W'(4);
            20: v = A_W'(2);
            21: v = A_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Gain compensation: multiply by 1/K in Q24 and round.
    function automatic logic signed [D_W-1:0] gain_fix(input logic signed [D_W-1:0] v);
        logic signed [P_W-1:0] p;
        p = P_W'(v) * P_W'(KINV_Q24) + P_W'(64'sd1 <<< 23);
        return D_W'(p >>> 24);
    endfunction

endpackage

// ----- hw/rtl/signed_heading_to_vector_angle_unit.sv -----
// Top level: signed angle from a heading to a 3-D vector, three CORDIC cell chains.
// Throughput is one request per cycle; the whole pipeline moves while the output is free.
// When the output stalls, the first stage still takes a request if it is empty.
// Reset (synchronous, active low) clears all valid bits; datapath registers are not reset.
module signed_heading_to_vector_angle_unit
    import shva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: vec_x [15:0], vec_y [31:16], vec_z [47:32], heading [64:48], zeros above
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: signed_angle [15:0]
    output logic [15:0] m_axis_tdata,
    // tuser: zero_vector [0]
    output logic        m_axis_tuser
);

    logic en;
    logic r_out_v;
    logic r_p_v;

    assign en            = ~r_out_v | m_axis_tready;
    assign s_axis_tready = en | ~r_p_v;

    // Input decode.
    logic signed [COMPONENT_WIDTH-1:0] in_x, in_y, in_z;
    logic signed [HEADING_WIDTH-1:0]   in_h;
    assign in_x = s_axis_tdata[15:0];
    assign in_y = s_axis_tdata[31:16];
    assign in_z = s_axis_tdata[47:32];
    assign in_h = s_axis_tdata[64:48];

    // Heading reduction and coarse 90-degree pre-rotation.
    logic signed [HEADING_WIDTH:0] h_red;
    logic signed [A_W-1:0]         a0, n_a;
    logic signed [D_W-1:0]         sx, sy, n_x, n_y;

    always_comb begin
        h_red = (HEADING_WIDTH+1)'(in_h);
        if (h_red >= (HEADING_WIDTH+1)'(HALF_TURN)) begin
            h_red = h_red - (HEADING_WIDTH+1)'(FULL_TURN);
        end else if (h_red < -(HEADING_WIDTH+1)'(HALF_TURN)) begin
            h_red = h_red + (HEADING_WIDTH+1)'(FULL_TURN);
        end
        a0 = -(A_W'(h_red) <<< 8);
        sx = D_W'(in_x) <<< GUARD_BITS;
        sy = D_W'(in_y) <<< GUARD_BITS;
        n_x = sx;
        n_y = sy;
        n_a = a0;
        if (a0 > DEG90) begin
            n_x = -sy;
            n_y = sx;
            n_a = a0 - DEG90;
        end else if (a0 < -DEG90) begin
            n_x = sy;
            n_y = -sx;
            n_a = a0 + DEG90;
        end
    end

    // Prep stage register.
    logic signed [D_W-1:0] r_p_x, r_p_y;
    logic signed [A_W-1:0] r_p_a;
    t_side                 r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_p_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_p_x         <= n_x;
            r_p_y         <= n_y;
            r_p_a         <= n_a;
            r_p_side.zero <= (in_x == '0) && (in_y == '0) && (in_z == '0);
            r_p_side.yneg <= 1'b0;
            r_p_side.xp   <= '0;
            r_p_side.z    <= D_W'(in_z) <<< GUARD_BITS;
        end
    end

    // Rotation chain: rotates (x, y) by minus the heading.
    logic                  rv [0:N_STG];
    logic signed [D_W-1:0] rx [0:N_STG];
    logic signed [D_W-1:0] ry [0:N_STG];
    logic signed [A_W-1:0] ra [0:N_STG];
    t_side                 rs [0:N_STG];

    assign rv[0] = r_p_v;
    assign rx[0] = r_p_x;
    assign ry[0] = r_p_y;
    assign ra[0] = r_p_a;
    assign rs[0] = r_p_side;

    for (genvar g = 0; g < N_STG; g++) begin : g_rot
        shva_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_mode_rot (1'b1),
            .i_shift    (SH_W'(g)),
            .i_atan     (atan_q(g)),
            .i_v        (rv[g]),
            .i_x        (rx[g]),
            .i_y        (ry[g]),
            .i_a        (ra[g]),
            .i_side     (rs[g]),
            .o_v        (rv[g+1]),
            .o_x        (rx[g+1]),
            .o_y        (ry[g+1]),
            .o_a        (ra[g+1]),
            .o_side     (rs[g+1])
        );
    end

    // Gain compensation of the rotated pair.
    logic                  r_g1_v;
    logic signed [D_W-1:0] r_g1_xp, r_g1_yp;
    t_side                 r_g1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_v <= 1'b0;
        end else if (en) begin
            r_g1_v <= rv[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1_xp   <= gain_fix(rx[N_STG]);
            r_g1_yp   <= gain_fix(ry[N_STG]);
            r_g1_side <= rs[N_STG];
        end
    end

    // Magnitude setup: absolute values of y' and z.
    logic                  r_m_v;
    logic signed [D_W-1:0] r_m_x, r_m_y;
    t_side                 r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_g1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_x         <= r_g1_yp[D_W-1] ? -r_g1_yp : r_g1_yp;
            r_m_y         <= r_g1_side.z[D_W-1] ? -r_g1_side.z : r_g1_side.z;
            r_m_side.zero <= r_g1_side.zero;
            r_m_side.yneg <= r_g1_yp[D_W-1];
            r_m_side.xp   <= r_g1_xp;
            r_m_side.z    <= r_g1_side.z;
        end
    end

    // Magnitude chain: vectors (|y'|, |z|) onto the x axis.
    logic                  mv [0:N_STG];
    logic signed [D_W-1:0] mx [0:N_STG];
    logic signed [D_W-1:0] my [0:N_STG];
    logic signed [A_W-1:0] ma [0:N_STG];
    t_side                 ms [0:N_STG];

    assign mv[0] = r_m_v;
    assign mx[0] = r_m_x;
    assign my[0] = r_m_y;
    assign ma[0] = '0;
    assign ms[0] = r_m_side;

    for (genvar g = 0; g < N_STG; g++) begin : g_mag
        shva_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_mode_rot (1'b0),
            .i_shift    (SH_W'(g)),
            .i_atan     (atan_q(g)),
            .i_v        (mv[g]),
            .i_x        (mx[g]),
            .i_y        (my[g]),
            .i_a        (ma[g]),
            .i_side     (ms[g]),
            .o_v        (mv[g+1]),
            .o_x        (mx[g+1]),
            .o_y        (my[g+1]),
            .o_a        (ma[g+1]),
            .o_side     (ms[g+1])
        );
    end

    // Gain compensation of the magnitude.
    logic                  r_g2_v;
    logic signed [D_W-1:0] r_g2_m;
    t_side                 r_g2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2_v <= 1'b0;
        end else if (en) begin
            r_g2_v <= mv[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g2_m    <= gain_fix(mx[N_STG]);
            r_g2_side <= ms[N_STG];
        end
    end

    // Angle setup: pre-rotate by 90 degrees when x' is negative.
    logic                  r_a_v;
    logic signed [D_W-1:0] r_a_x, r_a_y;
    logic signed [A_W-1:0] r_a_acc;
    t_side                 r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= r_g2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_g2_side.xp[D_W-1]) begin
                r_a_x   <= r_g2_m;
                r_a_y   <= -r_g2_side.xp;
                r_a_acc <= DEG90;
            end else begin
                r_a_x   <= r_g2_side.xp;
                r_a_y   <= r_g2_m;
                r_a_acc <= '0;
            end
            r_a_side <= r_g2_side;
        end
    end

    // Angle chain: accumulates the angle of (x', m).
    logic                  av [0:N_STG];
    logic signed [D_W-1:0] ax [0:N_STG];
    logic signed [D_W-1:0] ay [0:N_STG];
    logic signed [A_W-1:0] aa [0:N_STG];
    t_side                 as_ [0:N_STG];

    assign av[0]  = r_a_v;
    assign ax[0]  = r_a_x;
    assign ay[0]  = r_a_y;
    assign aa[0]  = r_a_acc;
    assign as_[0] = r_a_side;

    for (genvar g = 0; g < N_STG; g++) begin : g_ang
        shva_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_mode_rot (1'b0),
            .i_shift    (SH_W'(g)),
            .i_atan     (atan_q(g)),
            .i_v        (av[g]),
            .i_x        (ax[g]),
            .i_y        (ay[g]),
            .i_a        (aa[g]),
            .i_side     (as_[g]),
            .o_v        (av[g+1]),
            .o_x        (ax[g+1]),
            .o_y        (ay[g+1]),
            .o_a        (aa[g+1]),
            .o_side     (as_[g+1])
        );
    end

    // Final rounding, clamp and sign.
    logic signed [A_W-1:0] rnd;
    logic signed [A_W-9:0] res;
    logic signed [ANGLE_WIDTH-1:0] n_ang;

    always_comb begin
        rnd = (aa[N_STG] + A_W'(128)) >>> 8;
        res = (A_W-8)'(rnd);
        if (res < 0) begin
            res = '0;
        end else if (res > (A_W-8)'(HALF_TURN)) begin
            res = (A_W-8)'(HALF_TURN);
        end
        n_ang = ANGLE_WIDTH'(res);
        if (as_[N_STG].yneg) begin
            n_ang = -n_ang;
        end
        if (as_[N_STG].zero) begin
            n_ang = '0;
        end
    end

    // Output register.
    logic signed [ANGLE_WIDTH-1:0] r_out_ang;
    logic                          r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= av[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ang  <= n_ang;
            r_out_zero <= as_[N_STG].zero;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_ang;
    assign m_axis_tuser  = r_out_zero;

    // A zero vector always reports angle zero.
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_zero |-> r_out_ang == '0)
        else $error("zero vector with nonzero angle");

    // The angle stays within plus or minus 180 degrees.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_ang <= 16'sd23040) && (r_out_ang >= -16'sd23040))
        else $error("angle out of range");

    // A filled first stage holds its request while the pipeline is stalled.
    a_prep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v && !en |=> r_p_v && $stable(r_p_a))
        else $error("first stage lost a request during stall");

endmodule

// ----- hw/rtl/shva_cell.sv -----
// One CORDIC cell: a single micro-rotation with its pipeline register.
module shva_cell
    import shva_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_mode_rot,
    input  logic [SH_W-1:0]       i_shift,
    input  logic signed [A_W-1:0] i_atan,
    input  logic                  i_v,
    input  logic signed [D_W-1:0] i_x,
    input  logic signed [D_W-1:0] i_y,
    input  logic signed [A_W-1:0] i_a,
    input  t_side                 i_side,
    output logic                  o_v,
    output logic signed [D_W-1:0] o_x,
    output logic signed [D_W-1:0] o_y,
    output logic signed [A_W-1:0] o_a,
    output t_side                 o_side
);

    logic                  r_v;
    logic signed [D_W-1:0] r_x, r_y;
    logic signed [A_W-1:0] r_a;
    t_side                 r_side;
    logic signed [D_W-1:0] dx, dy;
    logic                  neg;

    // Direction: rotation drives the angle to zero, vectoring drives y to zero.
    assign dx  = i_y >>> i_shift;
    assign dy  = i_x >>> i_shift;
    assign neg = i_mode_rot ? i_a[A_W-1] : ~i_y[D_W-1];

    // Valid bit, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    // Micro-rotation.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (neg) begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_a <= i_a + i_atan;
            end else begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_a <= i_a - i_atan;
            end
            r_side <= i_side;
        end
    end

    assign o_v    = r_v;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_a    = r_a;
    assign o_side = r_side;

endmodule

// ----- test/tb_angle_checker.sv -----
// Checker that predicts and compares the results of the vector angle unit.
`timescale 1ns / 100ps

module tb_angle_checker
    import shva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [71:0] i_req_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_data,
    input  logic        i_res_user,
    output int          o_fail_count,
    output int          o_pending
);

    // One predicted result.
    typedef struct packed {
        logic signed [15:0] angle;
        logic               zero;
    } t_angle_res;

    localparam longint GUARD = 16;
    localparam longint KINV  = 10188012;
    localparam longint QDEG90 = 11520 * 256;

    t_angle_res angle_queue[$];

    // Table of arctangents in 2^-15 degree.
    function automatic longint atan_deg(input int idx);
        longint tab[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
                            14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
                            7, 4, 2, 1, 0, 0};
        return tab[idx];
    endfunction

    // Gain correction with rounding; >>> on longint floors.
    function automatic longint scale_gain(input longint v);
        return (v * KINV + (64'sd1 <<< 23)) >>> 24;
    endfunction

    // Predict the angle for one request.
    function automatic t_angle_res predict_angle(input logic [71:0] d);
        longint x, y, z, h, a, t, m, xp, yp, acc, res, dx, dy;
        int n;
        t_angle_res r;
        n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        h = longint'($signed(d[64:48]));
        if (x == 0 && y == 0 && z == 0) begin
            r.angle = '0;
            r.zero = 1'b1;
            return r;
        end
        x *= GUARD;
        y *= GUARD;
        z *= GUARD;
        while (h >= HALF_TURN) h -= FULL_TURN;
        while (h < -HALF_TURN) h += FULL_TURN;
        a = -h * 256;
        // Rotate the vector by minus the heading.
        if (a > QDEG90) begin
            t = x; x = -y; y = t; a -= QDEG90;
        end else if (a < -QDEG90) begin
            t = x; x = y; y = -t; a += QDEG90;
        end
        for (int i = 0; i < n; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (a >= 0) begin
                x -= dx; y += dy; a -= atan_deg(i);
            end else begin
                x += dx; y -= dy; a += atan_deg(i);
            end
        end
        xp = scale_gain(x);
        yp = scale_gain(y);
        // Length of (y', z).
        x = yp < 0 ? -yp : yp;
        y = z < 0 ? -z : z;
        for (int i = 0; i < n; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy;
            end else begin
                x -= dx; y += dy;
            end
        end
        m = scale_gain(x);
        // Angle of (x', length) over the half turn.
        if (xp < 0) begin
            x = m; y = -xp; acc = QDEG90;
        end else begin
            x = xp; y = m; acc = 0;
        end
        for (int i = 0; i < n; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += atan_deg(i);
            end else begin
                x -= dx; y += dy; acc -= atan_deg(i);
            end
        end
        res = (acc + 128) >>> 8;
        if (res < 0) res = 0;
        if (res > HALF_TURN) res = HALF_TURN;
        if (yp < 0) res = -res;
        r.angle = res[15:0];
        r.zero = 1'b0;
        return r;
    endfunction

    assign o_pending = angle_queue.size();

    // Predict on each request, compare on each result.
    always @(posedge i_clk) begin
        t_angle_res exp_res;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                angle_queue.push_back(predict_angle(i_req_data));
            if (i_res_valid && i_res_ready) begin
                if (angle_queue.size() == 0) begin
                    $error("unexpected result angle=%0d zero=%0b",
                           $signed(i_res_data), i_res_user);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = angle_queue.pop_front();
                    if (exp_res.angle !== i_res_data || exp_res.zero !== i_res_user) begin
                        if (exp_res.angle !== i_res_data)
                            $error("signed_angle expected %0d actual %0d",
                                   exp_res.angle, $signed(i_res_data));
                        if (exp_res.zero !== i_res_user)
                            $error("zero_vector expected %0b actual %0b",
                                   exp_res.zero, i_res_user);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top: stimulus, receiver stalls and verdict for the vector angle unit.
`timescale 1ns / 100ps

module tb;
    import shva_pkg::*;

    localparam int LATENCY = 3 * N_STG + 6;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    int          idle_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    signed_heading_to_vector_angle_unit dut (.*);

    tb_angle_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one request and wait until it is taken, with random idle cycles first.
    task automatic send_request(input logic [15:0] vx, input logic [15:0] vy,
                                input logic [15:0] vz, input logic [16:0] hd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, hd, vz, vy, vx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Random request: mostly full range, sometimes small components or exact headings.
    task automatic send_random;
        logic [15:0] c[3];
        logic [16:0] hd;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(5))
                0: c[k] = 16'($signed($urandom_range(8)) - 4);
                1: c[k] = '0;
                default: c[k] = 16'($urandom);
            endcase
        end
        if ($urandom_range(3) == 0)
            hd = 17'($signed(11520 * $urandom_range(8)) - 46080);
        else
            hd = 17'($urandom);
        send_request(c[0], c[1], c[2], hd);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, extremes, axis cases, headings at and past half turns.
        send_request(16'd0, 16'd0, 16'd0, 17'd0);
        send_request(16'd0, 16'd0, 16'd0, 17'h10000);
        send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 17'h0FFFF);
        send_request(16'h8000, 16'h8000, 16'h8000, 17'h10000);
        send_request(16'd100, 16'd0, 16'd0, 17'd0);
        send_request(16'hFF9C, 16'd0, 16'd0, 17'd0);
        send_request(16'd0, 16'd100, 16'd0, 17'd0);
        send_request(16'd0, 16'hFF9C, 16'd0, 17'd0);
        send_request(16'd0, 16'd0, 16'd100, 17'd0);
        send_request(16'd0, 16'd0, 16'h8000, 17'd11520);
        send_request(16'd1, 16'd0, 16'd0, 17'd23040);
        send_request(16'd1, 16'd0, 16'd0, 17'h1A600);
        send_request(16'd1, 16'd1, 16'd0, 17'h1D300);
        send_request(16'h8000, 16'h7FFF, 16'd0, 17'd34560);
        send_request(16'h7FFF, 16'h8000, 16'd1, 17'd46080);
        send_request(16'd0, 16'h7FFF, 16'd0, 17'd11520);
        send_request(16'd0, 16'd1, 16'd0, 17'd11521);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
        drain();

        // Random phases with different idle and stall rates.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 15) : 0;
            recv_stall_pct = (ph == 2) ? 67 : ((ph == 3) ? 15 : 0);
            for (int i = 0; i < 380; i++) send_random();
            // After the second phase the sender pauses until everything expected has come back.
            if (ph == 1) drain();
        end

        // Long receiver hold-off while the sender keeps offering requests.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 100; i++) send_random();
        join
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/shva_pkg.sv
hw/rtl/shva_cell.sv
hw/rtl/signed_heading_to_vector_angle_unit.sv
test/tb_angle_checker.sv
test/tb.sv
